@@ design/dlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Door lock controller package
// Shared status codes, configuration and result word types.
// ----------------------------------------------------------------------------
package dlpc_pkg;

   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_SECONDS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_SECONDS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_SECONDS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_SECONDS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATTEMPTS   = 3'd4;

   localparam logic [7:0] C_READY      = 8'h10;
   localparam logic [7:0] C_SAVED      = 8'h30;
   localparam logic [7:0] C_NOT_SAVED  = 8'h40;
   localparam logic [7:0] C_MATCHED    = 8'h50;
   localparam logic [7:0] C_NOT_MATCH  = 8'h60;
   localparam logic [7:0] C_OPEN       = 8'h80;
   localparam logic [7:0] C_CHANGE     = 8'h81;
   localparam logic [7:0] C_MENU       = 8'h90;
   localparam logic [7:0] C_LOCKING    = 8'h91;
   localparam logic [7:0] C_OPENED     = 8'h92;
   localparam logic [7:0] C_UNLOCKING  = 8'h93;
   localparam logic [7:0] C_EXISTS     = 8'h94;
   localparam logic [7:0] C_NOT_EXISTS = 8'h95;
   localparam logic [7:0] C_ALARM      = 8'h96;

   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_CW   = 2'd1;
   localparam logic [1:0] MOTOR_ACW  = 2'd2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_LVL_W = 3;

   typedef struct packed {
      logic [7:0] unlock_seconds;
      logic [7:0] hold_seconds;
      logic [7:0] lock_seconds;
      logic [7:0] alarm_seconds;
      logic [2:0] max_attempts;
   } cfg_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [1:0] motor_drive;
      logic       buzzer_active;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } core_res_type;

endpackage

@@ design/dlpc_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Link bytes and one-second ticks into the lock controller.
// ----------------------------------------------------------------------------
interface dlpc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

@@ design/dlpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Status words from the lock controller.
// ----------------------------------------------------------------------------
interface dlpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic [1:0] motor_drive;
   logic       buzzer_active;
   logic       last;

   modport source (output valid, output tx_byte, output motor_drive, output buzzer_active,
                   output last, input ready);
   modport sink   (input valid, input tx_byte, input motor_drive, input buzzer_active,
                   input last, output ready);
endinterface

@@ design/dlpc_core.sv @@
// ----------------------------------------------------------------------------
// Lock controller core
// Phase machine, password store, attempt and tick counters.
// ----------------------------------------------------------------------------
module dlpc_core #(
   parameter int PASS_LEN = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_cmd,
   input  logic [7:0]            in_byte,
   input  dlpc_pkg::cfg_type     cfg,
   output dlpc_pkg::core_res_type res
);

   localparam int CNT_W = $clog2(PASS_LEN + 1);
   localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;

   localparam logic [3:0] PH_START    = 4'd0;
   localparam logic [3:0] PH_NEW1_RDY = 4'd1;
   localparam logic [3:0] PH_NEW1     = 4'd2;
   localparam logic [3:0] PH_NEW2_RDY = 4'd3;
   localparam logic [3:0] PH_NEW2     = 4'd4;
   localparam logic [3:0] PH_MENU     = 4'd5;
   localparam logic [3:0] PH_CHK_RDY  = 4'd6;
   localparam logic [3:0] PH_CHK      = 4'd7;
   localparam logic [3:0] PH_UNLOCK   = 4'd8;
   localparam logic [3:0] PH_HOLD     = 4'd9;
   localparam logic [3:0] PH_LOCK     = 4'd10;
   localparam logic [3:0] PH_ALARM    = 4'd11;

   logic [3:0]       phase_ff, phase_in;
   logic [7:0]       pw_ff [PASS_LEN];
   logic             pw_valid_ff, pw_valid_in;
   logic [CNT_W-1:0] byte_index_ff, byte_index_in;
   logic             mismatch_ff, mismatch_in;
   logic [2:0]       fail_ff, fail_in;
   logic [7:0]       tick_ff, tick_in;
   logic             open_req_ff, open_req_in;
   logic [1:0]       motor_ff, motor_in;
   logic             buzzer_ff, buzzer_in;

   logic             pw_we;
   logic             first_old_motor;
   logic [7:0]       tick_inc;
   logic [CNT_W-1:0] idx_inc;
   logic             mism;
   logic [2:0]       fail_inc;
   logic [7:0]       tx0, tx1;
   logic [1:0]       n_res;
   logic [7:0]       pw_rd;

   assign tick_inc = tick_ff + 8'd1;
   assign idx_inc  = byte_index_ff + CNT_W'(1);
   assign pw_rd    = pw_ff[byte_index_ff[IDX_W-1:0]];
   assign mism     = mismatch_ff | (pw_rd != in_byte);
   assign fail_inc = (fail_ff != 3'd7) ? fail_ff + 3'd1 : fail_ff;

   always_comb begin
      phase_in        = phase_ff;
      pw_valid_in     = pw_valid_ff;
      byte_index_in   = byte_index_ff;
      mismatch_in     = mismatch_ff;
      fail_in         = fail_ff;
      tick_in         = tick_ff;
      open_req_in     = open_req_ff;
      motor_in        = motor_ff;
      buzzer_in       = buzzer_ff;
      pw_we           = 1'b0;
      first_old_motor = 1'b0;
      n_res           = 2'd0;
      tx0             = 8'h00;
      tx1             = 8'h00;
      if (in_cmd) begin
         case (phase_ff)
            PH_UNLOCK: begin
               if (tick_inc == cfg.unlock_seconds) begin
                  motor_in = dlpc_pkg::MOTOR_STOP;
                  tick_in  = 8'd0;
                  phase_in = PH_HOLD;
                  n_res    = 2'd1;
                  tx0      = dlpc_pkg::C_OPENED;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_HOLD: begin
               if (tick_inc == cfg.hold_seconds) begin
                  motor_in = dlpc_pkg::MOTOR_ACW;
                  tick_in  = 8'd0;
                  phase_in = PH_LOCK;
                  n_res    = 2'd1;
                  tx0      = dlpc_pkg::C_LOCKING;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_LOCK: begin
               if (tick_inc == cfg.lock_seconds) begin
                  motor_in = dlpc_pkg::MOTOR_STOP;
                  tick_in  = 8'd0;
                  phase_in = PH_MENU;
                  n_res    = 2'd1;
                  tx0      = dlpc_pkg::C_MENU;
               end else begin
                  tick_in = tick_inc;
               end
            end
            PH_ALARM: begin
               if (tick_inc == cfg.alarm_seconds) begin
                  buzzer_in = 1'b0;
                  tick_in   = 8'd0;
                  phase_in  = PH_MENU;
                  n_res     = 2'd1;
                  tx0       = dlpc_pkg::C_MENU;
               end else begin
                  tick_in = tick_inc;
               end
            end
            default: begin
            end
         endcase
      end else begin
         case (phase_ff)
            PH_NEW1_RDY, PH_NEW2_RDY, PH_CHK_RDY: begin
               if (in_byte == dlpc_pkg::C_READY) begin
                  byte_index_in = '0;
                  mismatch_in   = 1'b0;
                  phase_in      = phase_ff + 4'd1;
               end
            end
            PH_NEW1: begin
               pw_we         = 1'b1;
               byte_index_in = idx_inc;
               if (idx_inc == CNT_W'(PASS_LEN)) begin
                  phase_in = PH_NEW2_RDY;
               end
            end
            PH_NEW2, PH_CHK: begin
               if (idx_inc != CNT_W'(PASS_LEN)) begin
                  byte_index_in = idx_inc;
                  mismatch_in   = mism;
               end else begin
                  byte_index_in = '0;
                  mismatch_in   = 1'b0;
                  if (phase_ff == PH_NEW2) begin
                     if (mism) begin
                        phase_in = PH_NEW1_RDY;
                        n_res    = 2'd1;
                        tx0      = dlpc_pkg::C_NOT_SAVED;
                     end else begin
                        pw_valid_in = 1'b1;
                        phase_in    = PH_MENU;
                        n_res       = 2'd2;
                        tx0         = dlpc_pkg::C_SAVED;
                        tx1         = dlpc_pkg::C_MENU;
                     end
                  end else if (!mism) begin
                     tx0 = dlpc_pkg::C_MATCHED;
                     if (open_req_ff) begin
                        first_old_motor = 1'b1;
                        motor_in        = dlpc_pkg::MOTOR_CW;
                        tick_in         = 8'd0;
                        phase_in        = PH_UNLOCK;
                        n_res           = 2'd2;
                        tx1             = dlpc_pkg::C_UNLOCKING;
                     end else begin
                        phase_in = PH_NEW1_RDY;
                        n_res    = 2'd1;
                     end
                  end else begin
                     fail_in = fail_inc;
                     n_res   = 2'd1;
                     if (fail_inc < cfg.max_attempts) begin
                        phase_in = PH_CHK_RDY;
                        tx0      = dlpc_pkg::C_NOT_MATCH;
                     end else begin
                        buzzer_in = 1'b1;
                        tick_in   = 8'd0;
                        phase_in  = PH_ALARM;
                        tx0       = dlpc_pkg::C_ALARM;
                     end
                  end
               end
            end
            PH_MENU: begin
               if (in_byte == dlpc_pkg::C_OPEN || in_byte == dlpc_pkg::C_CHANGE) begin
                  open_req_in = (in_byte == dlpc_pkg::C_OPEN);
                  fail_in     = 3'd0;
                  phase_in    = PH_CHK_RDY;
               end else begin
                  n_res = 2'd1;
                  tx0   = dlpc_pkg::C_MENU;
               end
            end
            PH_UNLOCK, PH_HOLD, PH_LOCK, PH_ALARM: begin
            end
            default: begin
               if (in_byte == dlpc_pkg::C_READY) begin
                  if (pw_valid_ff) begin
                     phase_in = PH_MENU;
                     n_res    = 2'd2;
                     tx0      = dlpc_pkg::C_EXISTS;
                     tx1      = dlpc_pkg::C_MENU;
                  end else begin
                     phase_in = PH_NEW1_RDY;
                     n_res    = 2'd1;
                     tx0      = dlpc_pkg::C_NOT_EXISTS;
                  end
               end else begin
                  phase_in = PH_START;
               end
            end
         endcase
      end
   end

   always_comb begin
      res.count               = n_res;
      res.word0.tx_byte       = tx0;
      res.word0.motor_drive   = first_old_motor ? motor_ff : motor_in;
      res.word0.buzzer_active = buzzer_in;
      res.word0.last          = (n_res == 2'd1);
      res.word1.tx_byte       = tx1;
      res.word1.motor_drive   = motor_in;
      res.word1.buzzer_active = buzzer_in;
      res.word1.last          = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         pw_valid_ff   <= 1'b0;
         byte_index_ff <= '0;
         mismatch_ff   <= 1'b0;
         fail_ff       <= 3'd0;
         tick_ff       <= 8'd0;
         open_req_ff   <= 1'b0;
         motor_ff      <= dlpc_pkg::MOTOR_STOP;
         buzzer_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         pw_valid_ff   <= pw_valid_in;
         byte_index_ff <= byte_index_in;
         mismatch_ff   <= mismatch_in;
         fail_ff       <= fail_in;
         tick_ff       <= tick_in;
         open_req_ff   <= open_req_in;
         motor_ff      <= motor_in;
         buzzer_ff     <= buzzer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pw_we) begin
         pw_ff[byte_index_ff[IDX_W-1:0]] <= in_byte;
      end
   end

endmodule

@@ design/dlpc_fifo.sv @@
// ----------------------------------------------------------------------------
// Response queue
// Four-word queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module dlpc_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          push_count,
   input  dlpc_pkg::rsp_word_type              push_word0,
   input  dlpc_pkg::rsp_word_type              push_word1,
   input  logic                                pop,
   output dlpc_pkg::rsp_word_type              head,
   output logic [dlpc_pkg::FIFO_LVL_W-1:0]     level
);

   dlpc_pkg::rsp_word_type                 mem_ff [dlpc_pkg::FIFO_DEPTH];
   logic [dlpc_pkg::FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [dlpc_pkg::FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [dlpc_pkg::FIFO_LVL_W-1:0]        level_ff, level_in;
   logic [dlpc_pkg::FIFO_PTR_W-1:0]        wr_ptr_nxt;

   assign wr_ptr_nxt = wr_ptr_ff + dlpc_pkg::FIFO_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + dlpc_pkg::FIFO_PTR_W'(push_count);
   assign rd_ptr_in  = rd_ptr_ff + dlpc_pkg::FIFO_PTR_W'(pop);
   assign level_in   = level_ff + dlpc_pkg::FIFO_LVL_W'(push_count)
                       - dlpc_pkg::FIFO_LVL_W'(pop);
   assign head       = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push_word1;
      end
   end

endmodule

@@ design/door_lock_password_controller.sv @@
// ----------------------------------------------------------------------------
// Door lock password controller
// Password set-up, check, door open sequence and alarm, driven by link bytes
// and one-second ticks.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one word per event: cmd 0 with rx_byte for a received
//  link byte, cmd 1 for a one-second tick. rsp_chan returns status words
//  (tx_byte, motor_drive, buzzer_active); last marks the final word of an event.
//  An event gives none, one or two words.
//  An accepted word is held in the input word register; when the core advances,
//  its response words are written into the response queue and offered from there.
//  Throughput: one event per cycle while the four-word response queue has
//  room for two words; a two-word event takes two queue entries, which leave
//  one word at a time, so sustained rate is set by the queue drain.
//  When rsp_chan stalls the queue fills and req_chan.ready drops once the
//  held event can no longer be placed; nothing is dropped.
//  Reset (synchronous): phase returns to waiting for a ready byte, counters,
//  motor and buzzer clear, registers take their defaults (15, 3, 15, 60, 3).
//  The stored password is not cleared; it is only read after being written.
//  csr_* registers are to be written only when the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module door_lock_password_controller #(
   parameter int PASS_LEN = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   dlpc_req_if.sink                         req_chan,
   dlpc_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [dlpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dlpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   dlpc_pkg::cfg_type                   cfg_ff, cfg_in;
   logic                                in_valid_ff, in_valid_in;
   logic                                in_cmd_ff;
   logic [7:0]                          in_byte_ff;
   logic                                advance;
   logic                                accept;
   dlpc_pkg::core_res_type              res;
   dlpc_pkg::rsp_word_type              head;
   logic [dlpc_pkg::FIFO_LVL_W-1:0]     level;
   logic [1:0]                          push_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dlpc_pkg::CSR_UNLOCK_SECONDS: cfg_in.unlock_seconds = csr_write_data;
            dlpc_pkg::CSR_HOLD_SECONDS:   cfg_in.hold_seconds   = csr_write_data;
            dlpc_pkg::CSR_LOCK_SECONDS:   cfg_in.lock_seconds   = csr_write_data;
            dlpc_pkg::CSR_ALARM_SECONDS:  cfg_in.alarm_seconds  = csr_write_data;
            dlpc_pkg::CSR_MAX_ATTEMPTS:   cfg_in.max_attempts   = csr_write_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlock_seconds <= 8'd15;
         cfg_ff.hold_seconds   <= 8'd3;
         cfg_ff.lock_seconds   <= 8'd15;
         cfg_ff.alarm_seconds  <= 8'd60;
         cfg_ff.max_attempts   <= 3'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input word register
   assign advance        = in_valid_ff && (level <= dlpc_pkg::FIFO_LVL_W'(2));
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_chan.cmd;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   dlpc_core #(
      .PASS_LEN (PASS_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_cmd  (in_cmd_ff),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   assign push_count = advance ? res.count : 2'd0;

   dlpc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word0 (res.word0),
      .push_word1 (res.word1),
      .pop        (rsp_chan.valid && rsp_chan.ready),
      .head       (head),
      .level      (level)
   );

   assign rsp_chan.valid         = (level != '0);
   assign rsp_chan.tx_byte       = head.tx_byte;
   assign rsp_chan.motor_drive   = head.motor_drive;
   assign rsp_chan.buzzer_active = head.buzzer_active;
   assign rsp_chan.last          = head.last;

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= dlpc_pkg::FIFO_LVL_W'(dlpc_pkg::FIFO_DEPTH))
      else $error("response queue overflow");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      advance && res.count == 2'd2 |-> !res.word0.last && res.word1.last)
      else $error("last flag misplaced on two-word event");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |=> level != '0)
      else $error("pushed word not visible");

   a_motor_buzzer: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         !(rsp_chan.buzzer_active && rsp_chan.motor_drive != dlpc_pkg::MOTOR_STOP))
      else $error("motor driven while alarm sounds");
`endif

endmodule
